// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// File: rtl/core/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Constants shared by the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int CP_TDATA_W  = 24;
    localparam int LEFT_W      = 2;
    localparam int LEN_W       = 3;

    localparam logic [CP_W-1:0] REPL_CP     = 21'h00FFFD;
    localparam logic [CP_W-1:0] FLOOR_LEN2  = 21'h000080;
    localparam logic [CP_W-1:0] FLOOR_LEN3  = 21'h000800;
    localparam logic [CP_W-1:0] FLOOR_LEN4  = 21'h010000;

    localparam logic [LEN_W-1:0] LEN_IDLE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // One decoded result as it leaves the combinational step.
    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            end_of_stream;
    } u8_result_t;

endpackage

// File: rtl/core/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Byte-at-a-time UTF-8 decoder producing one code point per sequence.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one raw byte per transaction in s_axis_tdata, with
// s_axis_tlast marking the final byte of a source stream. The master stream
// carries one decoded code point per transaction: m_axis_tdata holds the
// value, m_axis_tuser flags a U+FFFD replacement (stray continuation,
// overlong form or truncated sequence) and m_axis_tlast marks the result
// caused by the final byte. Lead and middle bytes that are not final give no
// transaction on the master side.
// A result appears in the output register on the clock after the byte that
// completes it. Throughput is one byte per cycle while results are taken, set by
// the single decode step between the sequence state and the output register.
// When the receiver stalls with a result held, s_axis_tready drops until the
// result is taken; the held transaction is never lost or repeated.
// Reset clears the sequence state to idle and empties the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_decoder_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [u8dec_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] data_byte
    input  logic                               s_axis_tlast,  // last_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [u8dec_pkg::CP_TDATA_W-1:0]   m_axis_tdata,  // [20:0] code_point, [23:21] zero
    output logic                               m_axis_tuser,  // [0] replaced
    output logic                               m_axis_tlast   // end_of_stream
);
    import u8dec_pkg::*;

    logic [LEFT_W-1:0] bytes_left_reg;
    logic [LEFT_W-1:0] bytes_left_next;
    logic [LEN_W-1:0]  seq_length_reg;
    logic [LEN_W-1:0]  seq_length_next;
    logic [CP_W-1:0]   code_accum_reg;
    logic [CP_W-1:0]   code_accum_next;

    logic              m_valid_reg;
    logic [CP_W-1:0]   m_code_reg;
    logic              m_replaced_reg;
    logic              m_eos_reg;

    logic              s_fire;
    logic [CP_W-1:0]   accum_shift;
    logic [LEFT_W-1:0] left_dec;
    logic [CP_W-1:0]   floor_val;
    u8_result_t        res;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign accum_shift = {code_accum_reg[CP_W-7:0], s_axis_tdata[5:0]};
    assign left_dec    = bytes_left_reg - LEFT_W'(1);

    always_comb
    begin
        case (seq_length_reg)
            LEN_TWO:   floor_val = FLOOR_LEN2;
            LEN_THREE: floor_val = FLOOR_LEN3;
            default:   floor_val = FLOOR_LEN4;
        endcase
    end

    always_comb
    begin
        bytes_left_next   = '0;
        seq_length_next   = LEN_IDLE;
        code_accum_next   = '0;
        res.emit          = 1'b0;
        res.code_point    = REPL_CP;
        res.replaced      = 1'b1;
        // Every result carries the flag of the byte that caused it.
        res.end_of_stream = s_axis_tlast;

        if (bytes_left_reg == '0)
        begin
            if (s_axis_tdata[7:6] == 2'b10)
            begin
                res.emit = 1'b1;
            end
            else if (!s_axis_tdata[7])
            begin
                res.emit       = 1'b1;
                res.replaced   = 1'b0;
                res.code_point = CP_W'(s_axis_tdata);
            end
            else
            begin
                // Any lead with four high ones, F8-FF included, starts a 4-byte sequence.
                if (s_axis_tdata[7:4] == 4'hF)
                begin
                    seq_length_next = LEN_FOUR;
                    code_accum_next = CP_W'(s_axis_tdata[2:0]);
                end
                else if (s_axis_tdata[7:5] == 3'b111)
                begin
                    seq_length_next = LEN_THREE;
                    code_accum_next = CP_W'(s_axis_tdata[3:0]);
                end
                else
                begin
                    seq_length_next = LEN_TWO;
                    code_accum_next = CP_W'(s_axis_tdata[4:0]);
                end
                bytes_left_next = LEFT_W'(seq_length_next - LEN_W'(1));

                if (s_axis_tlast)
                begin
                    res.emit        = 1'b1;
                    bytes_left_next = '0;
                    seq_length_next = LEN_IDLE;
                    code_accum_next = '0;
                end
            end
        end
        else if (left_dec == '0)
        begin
            res.emit = 1'b1;
            if (accum_shift >= floor_val)
            begin
                res.replaced   = 1'b0;
                res.code_point = accum_shift;
            end
        end
        else if (s_axis_tlast)
        begin
            res.emit = 1'b1;
        end
        else
        begin
            bytes_left_next = left_dec;
            seq_length_next = seq_length_reg;
            code_accum_next = accum_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            seq_length_reg <= LEN_IDLE;
            code_accum_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                bytes_left_reg <= bytes_left_next;
                seq_length_reg <= seq_length_next;
                code_accum_reg <= code_accum_next;
            end
            if (s_fire && res.emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && res.emit)
        begin
            m_code_reg     <= res.code_point;
            m_replaced_reg <= res.replaced;
            m_eos_reg      <= res.end_of_stream;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = CP_TDATA_W'(m_code_reg);
    assign m_axis_tuser  = m_replaced_reg;
    assign m_axis_tlast  = m_eos_reg;

    `U8_ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
        m_valid_reg && !m_axis_tready, !s_axis_tready)
    `U8_ASSERT_SAME(a_idle_matches_length, clk, rst_n,
        1'b1, (bytes_left_reg == '0) == (seq_length_reg == LEN_IDLE))
    `U8_ASSERT_NEXT(a_final_byte_flushes, clk, rst_n,
        s_fire && s_axis_tlast, m_valid_reg && m_eos_reg && (bytes_left_reg == '0))
    `U8_ASSERT_SAME(a_replaced_is_fffd, clk, rst_n,
        m_valid_reg && m_replaced_reg, m_code_reg == REPL_CP)

endmodule

// File: bench/u8dec_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_scoreboard_pkg
// Byte-level decode prediction and code point checking for the UTF-8 decoder
// bench. Each accepted byte advances a private copy of the sequence state,
// and any code point it completes is queued until the master side delivers it.
// ----------------------------------------------------------------------------
package u8dec_scoreboard_pkg;

    import u8dec_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            end_of_stream;
    } cp_expect_t;

    class u8dec_scoreboard;

        logic [LEFT_W-1:0] bytes_left;
        logic [LEN_W-1:0]  seq_length;
        logic [CP_W-1:0]   code_accum;
        cp_expect_t        pending_points[$];
        int                mismatches;
        int                checked;
        int                replacements;
        int                stream_ends;

        function new();
            drop_sequence();
            mismatches   = 0;
            checked      = 0;
            replacements = 0;
            stream_ends  = 0;
        endfunction

        function void drop_sequence();
            bytes_left = '0;
            seq_length = LEN_IDLE;
            code_accum = '0;
        endfunction

        function void queue_point(logic [CP_W-1:0] cp, logic bad, logic eos);
            cp_expect_t pt;
            pt.code_point    = cp;
            pt.replaced      = bad;
            pt.end_of_stream = eos;
            pending_points.push_back(pt);
        endfunction

        function int points_waiting();
            return pending_points.size();
        endfunction

        // Advances the decode state by one accepted byte.
        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            logic [CP_W-1:0]  ascii_cp;
            logic [CP_W-1:0]  floor_cp;
            logic [CP_W-1:0]  cp;
            logic [LEN_W-1:0] len_less_one;
            if (bytes_left == '0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    drop_sequence();
                    queue_point(REPL_CP, 1'b1, last);
                end
                else if (!b[7])
                begin
                    drop_sequence();
                    ascii_cp = '0;
                    ascii_cp[BYTE_W-1:0] = b;
                    queue_point(ascii_cp, 1'b0, last);
                end
                else
                begin
                    // Anything from F0 up, F8-FF included, opens a four-byte sequence.
                    code_accum = '0;
                    if (b[7:4] == 4'b1111)
                    begin
                        seq_length = LEN_FOUR;
                        code_accum[2:0] = b[2:0];
                    end
                    else if (b[7:5] == 3'b111)
                    begin
                        seq_length = LEN_THREE;
                        code_accum[3:0] = b[3:0];
                    end
                    else
                    begin
                        seq_length = LEN_TWO;
                        code_accum[4:0] = b[4:0];
                    end
                    len_less_one = seq_length - 3'd1;
                    bytes_left = len_less_one[LEFT_W-1:0];
                    if (last)
                    begin
                        drop_sequence();
                        queue_point(REPL_CP, 1'b1, 1'b1);
                    end
                end
            end
            else
            begin
                // Follow-on bytes contribute their low six bits whatever the top two are.
                code_accum = {code_accum[CP_W-7:0], b[5:0]};
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == '0)
                begin
                    case (seq_length)
                        LEN_TWO:   floor_cp = FLOOR_LEN2;
                        LEN_THREE: floor_cp = FLOOR_LEN3;
                        default:   floor_cp = FLOOR_LEN4;
                    endcase
                    cp = code_accum;
                    drop_sequence();
                    if (cp < floor_cp)
                        queue_point(REPL_CP, 1'b1, last);
                    else
                        queue_point(cp, 1'b0, last);
                end
                else if (last)
                begin
                    drop_sequence();
                    queue_point(REPL_CP, 1'b1, 1'b1);
                end
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH: %s", msg);
        endtask

        task check_point(logic [CP_TDATA_W-1:0] tdata, logic tuser, logic tlast);
            cp_expect_t pt;
            if (pending_points.size() == 0)
            begin
                report($sformatf("code point 0x%06h arrived with nothing expected",
                                 tdata[CP_W-1:0]));
            end
            else
            begin
                pt = pending_points.pop_front();
                checked++;
                if (pt.replaced)
                    replacements++;
                if (pt.end_of_stream)
                    stream_ends++;
                if (tdata[CP_W-1:0] !== pt.code_point)
                    report($sformatf("transaction %0d: code point 0x%06h, expected 0x%06h",
                                     checked, tdata[CP_W-1:0], pt.code_point));
                if (tdata[CP_TDATA_W-1:CP_W] !== '0)
                    report($sformatf("transaction %0d: tdata padding bits are %b",
                                     checked, tdata[CP_TDATA_W-1:CP_W]));
                if (tuser !== pt.replaced)
                    report($sformatf("transaction %0d: replaced flag %b, expected %b",
                                     checked, tuser, pt.replaced));
                if (tlast !== pt.end_of_stream)
                    report($sformatf("transaction %0d: end-of-stream flag %b, expected %b",
                                     checked, tlast, pt.end_of_stream));
            end
        endtask

    endclass

endpackage

// File: bench/utf8_stream_decoder_core_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core_test
// Self-checking bench for the byte-at-a-time UTF-8 decoder. A short directed
// run hits boundary values, overlong forms, stray and truncated sequences;
// then mostly well-formed random sequences with some noise are streamed in
// bursts while the receiver stalls in several patterns, including one long
// hold-off that backs the decoder up into its input.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core_test;

    import u8dec_pkg::*;
    import u8dec_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 320;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [CP_TDATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    u8dec_scoreboard sb;
    rx_mode_t        rx_mode;
    int              hold_req;
    int              hold_done;
    bit              tx_gaps_on;
    int              burst_left;
    int              bytes_sent;
    int              input_stall_cycles;
    int              cycle_count;

    utf8_stream_decoder_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("** utf8_stream_decoder_core: FAILED **");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the byte was taken.
    task push_byte(logic [BYTE_W-1:0] b, logic last);
        int gap;
        if (tx_gaps_on && burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        sb.note_byte(b, last);
        burst_left--;
        bytes_sent++;
    endtask

    task send_random_sequence();
        int               kind;
        int               len;
        int               cut;
        bit               sloppy;
        logic [31:0]      rnd;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 99);
        rnd  = $urandom;
        if (kind < 25)
        begin
            push_byte({1'b0, rnd[6:0]}, $urandom_range(0, 29) == 0);
        end
        else if (kind < 90)
        begin
            len    = (kind < 45) ? 2 : (kind < 70) ? 3 : 4;
            sloppy = ($urandom_range(0, 9) == 0);
            // Now and then the stream ends inside the sequence, lead byte included.
            cut    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 2) : len;
            for (int i = 0; i < len; i++)
            begin
                rnd = $urandom;
                if (i == 0)
                    b = (len == 2) ? {3'b110, rnd[4:0]} :
                        (len == 3) ? {4'b1110, rnd[3:0]} : {4'b1111, rnd[3:0]};
                else if (sloppy)
                    b = rnd[7:0];
                else
                    b = {2'b10, rnd[5:0]};
                if (i == cut)
                begin
                    push_byte(b, 1'b1);
                    break;
                end
                push_byte(b, (i == len - 1) && ($urandom_range(0, 29) == 0));
            end
        end
        else if (kind < 95)
        begin
            push_byte({2'b10, rnd[5:0]}, $urandom_range(0, 9) == 0);
        end
        else
        begin
            push_byte(rnd[7:0], $urandom_range(0, 9) == 0);
        end
    endtask

    // Receiver: checks every master transaction and chooses its next ready.
    initial
    begin
        logic [15:0] stall_pattern;
        int          hold_left;
        logic        next_ready;
        m_axis_tready <= 1'b0;
        stall_pattern = 16'b1011_0010_1110_0111;
        hold_left     = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_point(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_done = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_RANDOM:  next_ready = ($urandom_range(0, 99) < 60);
                    RX_PATTERN:
                    begin
                        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                        next_ready    = stall_pattern[0];
                    end
                    RX_SPARSE:  next_ready = ($urandom_range(0, 7) == 0);
                    default:    next_ready = 1'b1;
                endcase
            end
            m_axis_tready <= next_ready;
        end
    end

    initial
    begin
        int target;
        sb                 = new();
        rx_mode            = RX_ALWAYS;
        hold_req           = 0;
        hold_done          = 0;
        tx_gaps_on         = 1'b0;
        burst_left         = 0;
        bytes_sent         = 0;
        input_stall_cycles = 0;
        cycle_count        = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: range ends, smallest and largest two- and three-byte forms, overlong
        // forms, pass-through beyond the Unicode range, stray and cut-off bytes.
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'hC2, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hDF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hC1, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hE0, 1'b0);
        push_byte(8'hA0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h8F, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        repeat (4) push_byte(8'hFF, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b1);
        push_byte(8'hC3, 1'b1);
        push_byte(8'hBF, 1'b1);

        target = bytes_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin rx_mode = RX_ALWAYS;  tx_gaps_on = 1'b0; end
                1:       begin rx_mode = RX_RANDOM;  tx_gaps_on = 1'b1; end
                2:       begin rx_mode = RX_PATTERN; tx_gaps_on = 1'b1; end
                default: begin rx_mode = RX_SPARSE;  tx_gaps_on = 1'b0; end
            endcase
            target += PHASE_BYTES;
            while (bytes_sent < target)
                send_random_sequence();
            if (phase == 1)
            begin
                // Receiver goes quiet while plain ASCII keeps coming, so the
                // output register fills and the input side must back off.
                tx_gaps_on = 1'b0;
                hold_req   = HOLD_CYCLES;
                for (int i = 0; i < 60; i++)
                    push_byte({1'b0, 7'(i + 32)}, 1'b0);
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        rx_mode = RX_ALWAYS;

        while (sb.points_waiting() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d bytes; %0d code points checked, %0d replacements, %0d stream ends.",
                 bytes_sent, sb.checked, sb.replacements, sb.stream_ends);
        $display("Input held back for %0d cycles, %0d of receiver hold-off in one stretch.",
                 input_stall_cycles, hold_done);
        if (sb.mismatches == 0)
            $display("** utf8_stream_decoder_core: PASSED **");
        else
            $display("** utf8_stream_decoder_core: FAILED **");
        $finish;
    end

endmodule
